>>> rtl/core/epwv_pkg.sv
// Shared types and codes for the EEPROM page-write/verify sequencer.
// No dependencies.
package epwv_pkg;

  typedef enum logic [2:0] {
    OP_LOAD     = 3'd0,
    OP_START_RD = 3'd1,
    OP_START_WR = 3'd2,
    OP_SERVICE  = 3'd3,
    OP_RESET    = 3'd4,
    OP_READBACK = 3'd5
  } op_e;

  typedef enum logic [2:0] {
    CMD_NONE   = 3'd0,
    CMD_READ   = 3'd1,
    CMD_PAGE   = 3'd2,
    CMD_POLL   = 3'd3,
    CMD_VERIFY = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    RES_IDLE    = 3'd0,
    RES_BUSY    = 3'd1,
    RES_SUCCESS = 3'd2,
    RES_INVALID = 3'd3,
    RES_COMM    = 3'd4,
    RES_VERIFY  = 3'd5
  } res_e;

  localparam logic [1:0] ST_BUSY     = 2'd0;
  localparam logic [1:0] ST_COMPLETE = 2'd1;
  localparam logic [1:0] ST_NOTREADY = 2'd2;

  localparam logic       CFG_IO_WAIT  = 1'b0;
  localparam logic       CFG_ACK_POLL = 1'b1;

  // One result item (before packing onto the bus).
  typedef struct packed {
    logic [2:0]  command;
    logic [15:0] cmd_address;
    logic [8:0]  cmd_length;
    logic [7:0]  write_byte;
    logic        clear_status;
    logic        write_protect;
    logic [2:0]  result_code;
    logic        accepted;
    logic        last;
  } item_t;

  // Controller -> datapath commands.
  typedef struct packed {
    logic       buf_wr;      // write buffer entry
    logic [7:0] buf_wr_idx;
    logic [7:0] buf_wr_data;
    logic       buf_rd;      // read buffer entry
    logic [7:0] buf_rd_idx;
  } dp_cmd_t;

  // Datapath -> controller status.
  typedef struct packed {
    logic [7:0] rd_data;
  } dp_sts_t;

endpackage

>>> rtl/core/epwv_buffer.sv
// Write-data buffer of the sequencer: 256 x 8 memory, one write and one
// registered read per cycle. Depends on epwv_pkg.
module epwv_buffer (
  input  logic              clk_i,
  input  epwv_pkg::dp_cmd_t cmd_i,
  output epwv_pkg::dp_sts_t sts_o
);

  logic [7:0] mem_q [256];
  logic [7:0] rd_q;

  // memory write and registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.buf_wr) begin
      mem_q[cmd_i.buf_wr_idx] <= cmd_i.buf_wr_data;
    end
    if (cmd_i.buf_rd) begin
      rd_q <= mem_q[cmd_i.buf_rd_idx];
    end
  end

  assign sts_o.rd_data = rd_q;

endmodule

>>> rtl/core/epwv_ctrl.sv
// Sequencer controller: decodes items, steps phases, emits result items.
// Depends on epwv_pkg; reads the buffer in epwv_buffer via command/status.
module epwv_ctrl #(
  parameter int unsigned PageSize    = 32,
  parameter int unsigned MemoryBytes = 32768,
  parameter int unsigned MaxTransfer = 256
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [2:0]        op_i,
  input  logic [15:0]       address_i,
  input  logic [15:0]       length_i,
  input  logic [7:0]        byte_index_i,
  input  logic [7:0]        data_byte_i,
  input  logic [1:0]        io_status_i,
  input  logic              start_refused_i,
  input  logic              cfg_valid_i,
  input  logic              cfg_index_i,
  input  logic              cfg_index_ok_i,
  input  logic [15:0]       cfg_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output epwv_pkg::item_t   item_o,
  output epwv_pkg::dp_cmd_t dp_cmd_o,
  input  epwv_pkg::dp_sts_t dp_sts_i
);

  localparam int unsigned PW = $clog2(PageSize + 1);

  typedef enum logic [3:0] {
    PH_IDLE, PH_START_READ, PH_WAIT_READ, PH_START_PAGE, PH_WAIT_PAGE,
    PH_START_POLL, PH_WAIT_POLL, PH_START_VERIFY, PH_WAIT_VERIFY
  } phase_e;

  // engine state: accept, emit result, stream page bytes, compare readback
  typedef enum logic [2:0] {
    EN_ACCEPT, EN_EMIT, EN_BYTES, EN_CMP_RD, EN_CMP
  } eng_e;

  phase_e      phase_q;
  eng_e        eng_q;
  logic [2:0]  res_q;
  logic [15:0] base_q;
  logic [8:0]  tlen_q;
  logic [8:0]  woff_q;
  logic [5:0]  plen_q;
  logic [7:0]  acks_q;
  logic [15:0] bwait_q;
  logic        mism_q;
  logic        prot_q;
  logic [15:0] io_lim_q;
  logic [7:0]  ack_lim_q;
  logic [5:0]  bcnt_q;
  logic [7:0]  cmp_data_q;
  logic        out_valid_q;
  epwv_pkg::item_t item_q;

  // page size computation from current offset
  logic [15:0] abs_addr;
  logic [PW-1:0] page_rem;
  logic [8:0]  xfer_rem;
  logic [8:0]  next_plen;
  logic [16:0] range_end;
  logic        range_ok;
  logic        slot_free;

  assign abs_addr  = base_q + {7'd0, woff_q};
  assign page_rem  = PW'(PageSize - (32'(abs_addr) % PageSize));
  assign xfer_rem  = tlen_q - woff_q;
  assign next_plen = (9'(page_rem) < xfer_rem) ? 9'(page_rem) : xfer_rem;
  assign range_end = {1'b0, address_i} + {1'b0, length_i};
  assign range_ok  = (length_i != 16'd0) && (32'(length_i) <= MaxTransfer) &&
                     (32'(range_end) <= MemoryBytes);

  assign slot_free  = !out_valid_q || out_ready_i;
  assign in_ready_o = (eng_q == EN_ACCEPT) && slot_free;
  assign out_valid_o = out_valid_q;
  assign item_o     = item_q;

  // buffer access commands
  always_comb begin
    dp_cmd_o = '0;
    dp_cmd_o.buf_wr      = in_valid_i && in_ready_o && op_i == epwv_pkg::OP_LOAD &&
                           phase_q == PH_IDLE;
    dp_cmd_o.buf_wr_idx  = byte_index_i;
    dp_cmd_o.buf_wr_data = data_byte_i;
    if (eng_q == EN_BYTES) begin
      dp_cmd_o.buf_rd     = 1'b1;
      dp_cmd_o.buf_rd_idx = woff_q[7:0] + {2'd0, bcnt_q};
    end else begin
      // read only for a readback transaction so read data holds otherwise
      dp_cmd_o.buf_rd     = (eng_q == EN_ACCEPT) && in_valid_i && in_ready_o &&
                            op_i == epwv_pkg::OP_READBACK;
      dp_cmd_o.buf_rd_idx = byte_index_i;
    end
  end

  // one clocked block: phase, engine and the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      eng_q       <= EN_ACCEPT;
      res_q       <= epwv_pkg::RES_IDLE;
      base_q      <= '0;
      tlen_q      <= '0;
      woff_q      <= '0;
      plen_q      <= '0;
      acks_q      <= '0;
      bwait_q     <= '0;
      mism_q      <= 1'b0;
      prot_q      <= 1'b1;
      io_lim_q    <= 16'd1000;
      ack_lim_q   <= 8'd10;
      bcnt_q      <= '0;
      cmp_data_q  <= '0;
      out_valid_q <= 1'b0;
      item_q      <= '0;
    end else begin
      logic        emit;
      logic [2:0]  e_cmd;
      logic [15:0] e_addr;
      logic [8:0]  e_len;
      logic        e_clr;
      logic        e_acc;
      logic        e_last;
      logic        waiting;
      logic [15:0] bw_inc;
      logic [7:0]  ack_inc;
      phase_e      ph;
      logic [2:0]  rs;
      logic        pr;
      logic        ov;
      epwv_pkg::item_t it;
      emit = 1'b0; e_cmd = epwv_pkg::CMD_NONE; e_addr = '0; e_len = '0;
      e_clr = 1'b0; e_acc = 1'b0; e_last = 1'b1; waiting = 1'b0;
      bw_inc = '0; ack_inc = acks_q + 8'd1;
      ph = phase_q; rs = res_q; pr = prot_q;
      ov = out_valid_q && !out_ready_i; it = item_q;

      if (cfg_valid_i && cfg_index_ok_i) begin
        if (cfg_index_i == epwv_pkg::CFG_IO_WAIT) io_lim_q <= cfg_data_i;
        else ack_lim_q <= cfg_data_i[7:0];
      end

      case (eng_q)
        EN_ACCEPT: begin
          if (in_valid_i && in_ready_o) begin
            emit = 1'b1;
            case (op_i)
              epwv_pkg::OP_START_RD, epwv_pkg::OP_START_WR: begin
                if (phase_q == PH_IDLE) begin
                  if (!range_ok) begin
                    rs = epwv_pkg::RES_INVALID;
                  end else begin
                    base_q  <= address_i;
                    tlen_q  <= length_i[8:0];
                    bwait_q <= '0;
                    rs = epwv_pkg::RES_BUSY;
                    e_acc = 1'b1;
                    if (op_i == epwv_pkg::OP_START_RD) begin
                      ph = PH_START_READ;
                    end else begin
                      woff_q <= '0; plen_q <= '0; acks_q <= '0; mism_q <= 1'b0;
                      ph = PH_START_PAGE;
                    end
                  end
                end
              end
              epwv_pkg::OP_RESET: begin
                if (phase_q == PH_IDLE) rs = epwv_pkg::RES_IDLE;
              end
              epwv_pkg::OP_READBACK: begin
                // buffer read issued this cycle; compare next
                if (phase_q == PH_WAIT_VERIFY && {1'b0, byte_index_i} < tlen_q) begin
                  emit = 1'b0;
                  cmp_data_q <= data_byte_i;
                  eng_q <= EN_CMP;
                end
              end
              epwv_pkg::OP_SERVICE: begin
                // busy status handling shared by wait phases
                if (io_status_i == epwv_pkg::ST_BUSY) begin
                  bw_inc = (bwait_q != 16'hFFFF) ? bwait_q + 16'd1 : bwait_q;
                end
                case (phase_q)
                  PH_START_READ, PH_START_POLL, PH_START_VERIFY: begin
                    e_clr = 1'b1;
                    if (start_refused_i) begin
                      pr = 1'b1; rs = epwv_pkg::RES_COMM; ph = PH_IDLE;
                    end else if (phase_q == PH_START_READ) begin
                      ph = PH_WAIT_READ; e_cmd = epwv_pkg::CMD_READ;
                      e_addr = base_q; e_len = tlen_q;
                    end else if (phase_q == PH_START_POLL) begin
                      ph = PH_WAIT_POLL; e_cmd = epwv_pkg::CMD_POLL;
                    end else begin
                      ph = PH_WAIT_VERIFY; e_cmd = epwv_pkg::CMD_VERIFY;
                      e_addr = base_q; e_len = tlen_q;
                    end
                  end
                  PH_START_PAGE: begin
                    e_clr = 1'b1;
                    plen_q <= next_plen[5:0];
                    if (start_refused_i) begin
                      pr = 1'b1; rs = epwv_pkg::RES_COMM; ph = PH_IDLE;
                    end else begin
                      pr = 1'b0; ph = PH_WAIT_PAGE; e_cmd = epwv_pkg::CMD_PAGE;
                      e_addr = abs_addr; e_len = next_plen;
                      if (next_plen != 9'd0) begin
                        e_last = 1'b0;
                        bcnt_q <= '0;
                        eng_q  <= EN_BYTES;
                      end
                    end
                  end
                  PH_WAIT_READ, PH_WAIT_PAGE, PH_WAIT_POLL, PH_WAIT_VERIFY: begin
                    waiting = io_status_i == epwv_pkg::ST_BUSY;
                    if (waiting) begin
                      bwait_q <= bw_inc;
                      if (bw_inc >= io_lim_q) begin
                        pr = 1'b1; rs = epwv_pkg::RES_COMM; ph = PH_IDLE;
                      end
                    end else begin
                      bwait_q <= '0;
                      e_clr = 1'b1;
                      case (phase_q)
                        PH_WAIT_READ: begin
                          pr = 1'b1; ph = PH_IDLE;
                          rs = (io_status_i == epwv_pkg::ST_COMPLETE) ?
                               epwv_pkg::RES_SUCCESS : epwv_pkg::RES_COMM;
                        end
                        PH_WAIT_PAGE: begin
                          pr = 1'b1;
                          if (io_status_i != epwv_pkg::ST_COMPLETE) begin
                            rs = epwv_pkg::RES_COMM; ph = PH_IDLE;
                          end else begin
                            acks_q <= '0; ph = PH_START_POLL;
                          end
                        end
                        PH_WAIT_POLL: begin
                          if (io_status_i == epwv_pkg::ST_COMPLETE) begin
                            woff_q <= woff_q + {3'd0, plen_q};
                            ph = ((woff_q + {3'd0, plen_q}) < tlen_q) ?
                                 PH_START_PAGE : PH_START_VERIFY;
                          end else if (io_status_i == epwv_pkg::ST_NOTREADY) begin
                            acks_q <= ack_inc;
                            if (ack_inc < ack_lim_q) ph = PH_START_POLL;
                            else begin
                              pr = 1'b1; rs = epwv_pkg::RES_COMM; ph = PH_IDLE;
                            end
                          end else begin
                            pr = 1'b1; rs = epwv_pkg::RES_COMM; ph = PH_IDLE;
                          end
                        end
                        default: begin
                          pr = 1'b1; ph = PH_IDLE;
                          if (io_status_i != epwv_pkg::ST_COMPLETE)
                            rs = epwv_pkg::RES_COMM;
                          else if (mism_q) rs = epwv_pkg::RES_VERIFY;
                          else rs = epwv_pkg::RES_SUCCESS;
                        end
                      endcase
                    end
                  end
                  default: ;
                endcase
              end
              default: ;
            endcase
          end
        end
        EN_CMP: begin
          if (dp_sts_i.rd_data != cmp_data_q) mism_q <= 1'b1;
          eng_q <= EN_EMIT;
        end
        EN_EMIT: begin
          if (slot_free) begin
            emit  = 1'b1;
            eng_q <= EN_ACCEPT;
          end
        end
        EN_BYTES: begin
          // buffer read issued; data arrives next cycle
          eng_q <= EN_CMP_RD;
        end
        EN_CMP_RD: begin
          if (slot_free) begin
            ov = 1'b1;
            it = '{command: epwv_pkg::CMD_NONE, cmd_address: '0,
                   cmd_length: '0, write_byte: dp_sts_i.rd_data,
                   clear_status: 1'b0, write_protect: prot_q,
                   result_code: res_q, accepted: 1'b0,
                   last: (bcnt_q + 6'd1) == plen_q};
            bcnt_q <= bcnt_q + 6'd1;
            eng_q <= ((bcnt_q + 6'd1) == plen_q) ? EN_ACCEPT : EN_BYTES;
          end
        end
        default: eng_q <= EN_ACCEPT;
      endcase

      phase_q <= ph;
      res_q   <= rs;
      prot_q  <= pr;
      if (emit) begin
        ov = 1'b1;
        it = '{command: e_cmd, cmd_address: e_addr, cmd_length: e_len,
               write_byte: '0, clear_status: e_clr, write_protect: pr,
               result_code: rs, accepted: e_acc, last: e_last};
      end
      out_valid_q <= ov;
      item_q      <= it;
    end
  end

endmodule

>>> rtl/core/eeprom_page_write_verify_sequencer.sv
// Top level of the EEPROM page-write/verify sequencer: stream ports,
// config port, controller (epwv_ctrl) and write buffer (epwv_buffer).
// Each result item is driven from the output register; a compared readback
// byte first passes the compare state, and a page command is followed by one
// data byte per page byte (buffer read then output register). Throughput: one
// item per cycle unless the output stalls; readbacks and page bytes hold input.
// Reset (rst_ni low, asynchronous): idle, write protect on, limits 1000/10.
module eeprom_page_write_verify_sequencer #(
  parameter int unsigned PageSize    = 32,
  parameter int unsigned MemoryBytes = 32768,
  parameter int unsigned MaxTransfer = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // operation[2:0], address[18:3], length[34:19], byte_index[42:35],
  // data_byte[50:43], io_status[52:51], start_refused[53], zero pad
  input  logic [55:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // command[2:0], cmd_address[18:3], cmd_length[27:19], write_byte[35:28],
  // clear_status[36], write_protect[37], result_code[40:38], accepted[41]
  output logic [47:0] m_axis_tdata,
  output logic        m_axis_tlast,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [0:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  epwv_pkg::item_t   item;
  epwv_pkg::dp_cmd_t dp_cmd;
  epwv_pkg::dp_sts_t dp_sts;

  assign cfg_ready_o = 1'b1;

  epwv_ctrl #(
    .PageSize(PageSize), .MemoryBytes(MemoryBytes), .MaxTransfer(MaxTransfer)
  ) u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i     (s_axis_tvalid),
    .in_ready_o     (s_axis_tready),
    .op_i           (s_axis_tdata[2:0]),
    .address_i      (s_axis_tdata[18:3]),
    .length_i       (s_axis_tdata[34:19]),
    .byte_index_i   (s_axis_tdata[42:35]),
    .data_byte_i    (s_axis_tdata[50:43]),
    .io_status_i    (s_axis_tdata[52:51]),
    .start_refused_i(s_axis_tdata[53]),
    .cfg_valid_i,
    .cfg_index_i    (cfg_index_i[0]),
    .cfg_index_ok_i (1'b1),
    .cfg_data_i,
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .item_o         (item),
    .dp_cmd_o       (dp_cmd),
    .dp_sts_i       (dp_sts)
  );

  epwv_buffer u_buf (
    .clk_i,
    .cmd_i(dp_cmd),
    .sts_o(dp_sts)
  );

  // pack result item
  assign m_axis_tdata = {6'd0, item.accepted, item.result_code, item.write_protect,
                         item.clear_status, item.write_byte, item.cmd_length,
                         item.cmd_address, item.command};
  assign m_axis_tlast = item.last;

endmodule
